/* src/als_pkg.sv */
// shared constants and types for the antialiased line stepper
`default_nettype none
package als_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int WEIGHT_BITS_DEF = 8;

    localparam int CFG_BITS = 13;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

endpackage
`default_nettype wire

/* src/als_if.sv */
// valid/ready channel interfaces for line items and pixel pairs
`default_nettype none
interface als_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface als_out_if #(parameter int COORD_BITS = 16, parameter int WEIGHT_BITS = 8);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] main_x;
    logic signed [COORD_BITS-1:0] main_y;
    logic        [WEIGHT_BITS:0]  main_weight;
    logic                         main_valid;
    logic signed [COORD_BITS-1:0] side_x;
    logic signed [COORD_BITS-1:0] side_y;
    logic        [WEIGHT_BITS:0]  side_weight;
    logic                         side_valid;
    logic                         line_done;
    modport source (output valid, main_x, main_y, main_weight, main_valid,
                    side_x, side_y, side_weight, side_valid, line_done, input ready);
    modport sink (input valid, main_x, main_y, main_weight, main_valid,
                  side_x, side_y, side_weight, side_valid, line_done, output ready);
endinterface
`default_nettype wire

/* src/als_front.sv */
// front end: accepts items, does octant setup for loads, pushes commands
`default_nettype none
module als_front
    import als_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    als_in_if.sink                   line_in,
    input  wire logic                q_full,
    output logic                     q_push,
    output logic [5*COORD_BITS+4:0]  q_data
);
    localparam int C = COORD_BITS;

    logic signed [C:0]   ddx, ddy, dmaj, dmin;
    logic        [C:0]   adx, ady, amin;
    logic                steep, neg;
    logic signed [C-1:0] a0, a1, b0, b1, p0, p1, m0, m1;

    always_comb
    begin
        ddx   = {line_in.end_x[C-1], line_in.end_x} - {line_in.start_x[C-1], line_in.start_x};
        ddy   = {line_in.end_y[C-1], line_in.end_y} - {line_in.start_y[C-1], line_in.start_y};
        adx   = ddx[C] ? $unsigned(-ddx) : $unsigned(ddx);
        ady   = ddy[C] ? $unsigned(-ddy) : $unsigned(ddy);
        steep = ady > adx;
        a0 = steep ? line_in.start_y : line_in.start_x;
        b0 = steep ? line_in.start_x : line_in.start_y;
        a1 = steep ? line_in.end_y   : line_in.end_x;
        b1 = steep ? line_in.end_x   : line_in.end_y;
        if (a0 > a1)
        begin
            p0 = a1; m0 = b1; p1 = a0; m1 = b0;
        end
        else
        begin
            p0 = a0; m0 = b0; p1 = a1; m1 = b1;
        end
        dmaj = {p1[C-1], p1} - {p0[C-1], p0};
        dmin = {m1[C-1], m1} - {m0[C-1], m0};
        neg  = dmin[C];
        amin = neg ? $unsigned(-dmin) : $unsigned(dmin);
        q_data = {line_in.op, steep, neg, p0, p1, m0, $unsigned(dmaj), amin};
    end

    assign line_in.ready = !q_full;
    assign q_push        = line_in.valid && !q_full;
endmodule
`default_nettype wire

/* src/als_queue.sv */
// two-entry command queue between front and back
`default_nettype none
module als_queue
    import als_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output q_ctl_t            ctl,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      pop_data
);
    logic [W-1:0] mem_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    assign ctl.push  = push;
    assign ctl.full  = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_data  = mem_reg[rptr_reg];
endmodule
`default_nettype wire

/* src/als_back.sv */
// back end: line state, serial weight divider and output register
`default_nettype none
module als_back
    import als_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [CFG_BITS-1:0]     image_width,
    input  wire logic [CFG_BITS-1:0]     image_height,
    input  wire logic                    q_valid,
    input  wire logic [5*COORD_BITS+4:0] q_data,
    output logic                         q_pop,
    als_out_if.source                    pixel_out
);
    localparam int C  = COORD_BITS;
    localparam int WB = WEIGHT_BITS;
    localparam int CW = $clog2(WB + 1);
    localparam int XW = C + CFG_BITS;
    localparam logic [WB:0] FULL = (WB+1)'(1) << WB;
    localparam logic [WB:0] HALF = (WB+1)'(1) << (WB - 1);

    back_state_t state_reg, state_next;

    logic                swp_reg, neg_reg, active_reg;
    logic signed [C-1:0] maj_pos_reg, maj_end_reg, min_pos_reg;
    logic        [C:0]   dx_reg, dy_reg;
    logic signed [C+1:0] err_reg;
    logic        [C+2:0] rem_reg;
    logic        [WB:0]  f_reg;
    logic        [CW-1:0] cnt_reg;

    logic                out_valid_reg;
    logic signed [C-1:0] mx_reg, my_reg, sx_reg, sy_reg;
    logic        [WB:0]  mw_reg, sw_reg;
    logic                mv_reg, sv_reg, done_reg;

    // command fields
    logic                c_op, c_swp, c_neg;
    logic signed [C-1:0] c_p0, c_p1, c_m0;
    logic        [C:0]   c_dx, c_dy;

    logic signed [C+3:0] n0, dd;
    logic        [C+2:0] rem2;
    logic                rem_ge;
    logic signed [C-1:0] min_step, mx, my, sx, sy;
    logic signed [C+2:0] s_err;
    logic signed [C+3:0] s2;
    logic                take_out, is_last, load_out;

    function automatic logic in_range(input logic signed [C-1:0] v,
                                      input logic [CFG_BITS-1:0] lim);
        return !v[C-1] && (XW'($unsigned(v)) < XW'(lim));
    endfunction

    assign {c_op, c_swp, c_neg, c_p0, c_p1, c_m0, c_dx, c_dy} = q_data;

    always_comb
    begin
        n0       = ((C+4)'(signed'(err_reg)) <<< 1) + signed'((C+4)'(dx_reg));
        dd       = signed'((C+4)'(dx_reg)) <<< 1;
        rem2     = rem_reg << 1;
        rem_ge   = rem2 >= (C+3)'(dx_reg) << 1;
        min_step = neg_reg ? min_pos_reg - C'(1) : min_pos_reg + C'(1);
        mx       = swp_reg ? min_pos_reg : maj_pos_reg;
        my       = swp_reg ? maj_pos_reg : min_pos_reg;
        sx       = swp_reg ? min_step : maj_pos_reg;
        sy       = swp_reg ? maj_pos_reg : min_step;
        s_err    = (C+3)'(err_reg) + signed'((C+3)'(dy_reg));
        s2       = (C+4)'(s_err) <<< 1;
        is_last  = maj_pos_reg >= maj_end_reg;
        take_out = !out_valid_reg || pixel_out.ready;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (c_op == OP_STEP)
                    begin
                        if (!active_reg || dx_reg == '0 || n0 < 0 || n0 >= dd)
                            state_next = ST_EMIT;
                        else
                            state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CW'(WB - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (take_out)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            swp_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            maj_pos_reg   <= '0;
            maj_end_reg   <= '0;
            min_pos_reg   <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && c_op == OP_LOAD)
            begin
                swp_reg     <= c_swp;
                neg_reg     <= c_neg;
                maj_pos_reg <= c_p0;
                maj_end_reg <= c_p1;
                min_pos_reg <= c_m0;
                dx_reg      <= c_dx;
                dy_reg      <= c_dy;
                err_reg     <= '0;
                active_reg  <= 1'b1;
            end
            if (load_out && active_reg)
            begin
                if (s2 < signed'((C+4)'(dx_reg)))
                    err_reg <= (C+2)'(s_err);
                else
                begin
                    err_reg     <= (C+2)'(s_err - signed'((C+3)'(dx_reg)));
                    min_pos_reg <= min_step;
                end
                if (is_last)
                    active_reg <= 1'b0;
                else
                    maj_pos_reg <= maj_pos_reg + C'(1);
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pixel_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // divider datapath: one quotient bit per cycle; also loads the output pixel pair
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            cnt_reg <= '0;
            rem_reg <= (C+3)'(n0);
            if (dx_reg == '0)
                f_reg <= HALF;
            else if (n0 < 0)
                f_reg <= '0;
            else if (n0 >= dd)
                f_reg <= FULL;
            else
                f_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            f_reg   <= {f_reg[WB-1:0], rem_ge};
            rem_reg <= rem_ge ? rem2 - ((C+3)'(dx_reg) << 1) : rem2;
        end
        if (load_out)
        begin
            if (active_reg)
            begin
                mx_reg   <= mx;
                my_reg   <= my;
                sx_reg   <= sx;
                sy_reg   <= sy;
                mw_reg   <= FULL - f_reg;
                sw_reg   <= f_reg;
                mv_reg   <= in_range(mx, image_width) && in_range(my, image_height);
                sv_reg   <= in_range(sx, image_width) && in_range(sy, image_height);
                done_reg <= is_last;
            end
            else
            begin
                mx_reg   <= '0;
                my_reg   <= '0;
                sx_reg   <= '0;
                sy_reg   <= '0;
                mw_reg   <= '0;
                sw_reg   <= '0;
                mv_reg   <= 1'b0;
                sv_reg   <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.main_x      = mx_reg;
    assign pixel_out.main_y      = my_reg;
    assign pixel_out.main_weight = mw_reg;
    assign pixel_out.main_valid  = mv_reg;
    assign pixel_out.side_x      = sx_reg;
    assign pixel_out.side_y      = sy_reg;
    assign pixel_out.side_weight = sw_reg;
    assign pixel_out.side_valid  = sv_reg;
    assign pixel_out.line_done   = done_reg;
endmodule
`default_nettype wire

/* src/antialiased_line_stepper.sv */
// top level of the antialiased all-octant line stepper
//
// channel    dir  modport  moves
// line_in    in   sink     one load or step command per transfer
// pixel_out  out  source   one pixel pair per step transfer
// apb        in   slave    image_width at 0x0, image_height at 0x4
//
// a load is taken by the back end from idle and gives no result
// a step runs the serial weight divider (one quotient bit per cycle) unless the
// weight is clamped, half or no line is active
// the two-entry queue lets line_in keep taking transfers while the back end works
// the output register holds a pixel pair until taken; the back end stalls in emit
// reset clears line state and queue; image size returns to 640 by 480
`default_nettype none
module antialiased_line_stepper
    import als_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    als_in_if.sink           line_in,
    als_out_if.source        pixel_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CMD_W = 5*COORD_BITS + 5;

    logic [CFG_BITS-1:0] width_reg, height_reg;
    logic                q_push, q_pop, q_nempty;
    logic [CMD_W-1:0]    q_in, q_out;
    q_ctl_t              q_ctl;

    // configuration registers, written in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[CFG_BITS-1:0];
            else
                height_reg <= pwdata[CFG_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    // front end: octant setup for loads
    als_front #(.COORD_BITS(COORD_BITS)) u_front (
        .line_in (line_in),
        .q_full  (q_ctl.full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    als_queue #(.W(CMD_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ctl       (q_ctl),
        .pop       (q_pop),
        .not_empty (q_nempty),
        .pop_data  (q_out)
    );

    // back end: stepping, weights, clipping
    als_back #(.COORD_BITS(COORD_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_valid      (q_nempty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .pixel_out    (pixel_out)
    );
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// testbench for the antialiased line stepper: random line loads and steps checked against a predictor
`timescale 1ns / 1ps
module tb;
    import als_pkg::*;

    localparam int CB = 16;
    localparam int WB = 8;
    localparam int FULL = 1 << WB;

    // one expected pixel pair
    typedef struct packed {
        logic signed [CB-1:0] main_x;
        logic signed [CB-1:0] main_y;
        logic [WB:0]          main_weight;
        logic                 main_valid;
        logic signed [CB-1:0] side_x;
        logic signed [CB-1:0] side_y;
        logic [WB:0]          side_weight;
        logic                 side_valid;
        logic                 line_done;
    } pixel_pair_t;

    // predictor and store of expected pixel pairs
    class line_scoreboard;
        logic [12:0] img_w, img_h;
        bit swapped, minor_neg, active;
        longint mpos, mend, npos, mdelta, ndelta, err;
        pixel_pair_t pending[$];
        int errors;

        function new();
            img_w = WIDTH_RESET;
            img_h = HEIGHT_RESET;
            errors = 0;
        endfunction

        function longint wrap16(longint v);
            logic signed [CB-1:0] w;
            w = v[CB-1:0];
            return longint'(w);
        endfunction

        function bit in_image(longint x, longint y);
            return x >= 0 && y >= 0 && x < img_w && y < img_h;
        endfunction

        // note one accepted line command and predict its pixel pair
        function void note_command(logic op, logic signed [CB-1:0] x0i, y0i, x1i, y1i);
            longint x0, y0, x1, y1, t, dy, f, num, den, dir, mx, my, sx, sy;
            pixel_pair_t p;
            if (op == OP_LOAD)
            begin
                x0 = x0i; y0 = y0i; x1 = x1i; y1 = y1i;
                swapped = ((y1 - y0) < 0 ? y0 - y1 : y1 - y0) > ((x1 - x0) < 0 ? x0 - x1 : x1 - x0);
                if (swapped)
                begin
                    t = x0; x0 = y0; y0 = t;
                    t = x1; x1 = y1; y1 = t;
                end
                if (x0 > x1)
                begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                dy = y1 - y0;
                minor_neg = dy < 0;
                mpos = x0; mend = x1; npos = y0;
                mdelta = x1 - x0;
                ndelta = dy < 0 ? -dy : dy;
                err = 0;
                active = 1;
                return;
            end
            p = '0;
            if (!active)
            begin
                p.line_done = 1'b1;
                pending.push_back(p);
                return;
            end
            if (mdelta == 0)
                f = FULL / 2;
            else
            begin
                num = (2 * err + mdelta) * FULL;
                den = 2 * mdelta;
                f = num / den;
                if (num % den != 0 && num < 0)
                    f -= 1;
                if (f < 0) f = 0;
                if (f > FULL) f = FULL;
            end
            dir = minor_neg ? -1 : 1;
            if (swapped)
            begin
                mx = npos; my = mpos; sx = wrap16(mx + dir); sy = my;
            end
            else
            begin
                mx = mpos; my = npos; sx = mx; sy = wrap16(my + dir);
            end
            p.main_x = mx[CB-1:0];
            p.main_y = my[CB-1:0];
            p.main_weight = (WB+1)'(FULL - f);
            p.main_valid = in_image(mx, my);
            p.side_x = sx[CB-1:0];
            p.side_y = sy[CB-1:0];
            p.side_weight = (WB+1)'(f);
            p.side_valid = in_image(sx, sy);
            if (2 * (err + ndelta) < mdelta)
                err += ndelta;
            else
            begin
                err += ndelta - mdelta;
                npos = wrap16(npos + dir);
            end
            p.line_done = mpos >= mend;
            if (p.line_done)
                active = 0;
            else
                mpos += 1;
            pending.push_back(p);
        endfunction

        // compare one received pixel pair with the oldest expectation
        function void check_pair(pixel_pair_t got);
            pixel_pair_t exp_p;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel pair %p", got);
                return;
            end
            exp_p = pending.pop_front();
            if (got !== exp_p)
            begin
                errors++;
                if (errors <= 10)
                    $display("pixel pair mismatch: expected %p got %p", exp_p, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    als_in_if #(.COORD_BITS(CB)) line_in ();
    als_out_if #(.COORD_BITS(CB), .WEIGHT_BITS(WB)) pixel_out ();

    antialiased_line_stepper dut (
        .clk(clk), .rst_n(rst_n),
        .line_in(line_in.sink), .pixel_out(pixel_out.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    line_scoreboard sb = new();
    bit stim_done = 0;
    bit hold_off = 0;   // long receiver stall requested by the stimulus

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        line_in.valid = 1'b0;
        line_in.op = OP_LOAD;
        line_in.start_x = '0;
        line_in.start_y = '0;
        line_in.end_x = '0;
        line_in.end_y = '0;
        pixel_out.ready = 1'b0;
    end

    // mostly short gaps, occasionally long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, checks every transfer
    initial
    begin : receiver
        int g;
        pixel_pair_t got;
        @(posedge rst_n);
        forever
        begin
            g = hold_off ? 300 : gap_len();
            if (hold_off)
                hold_off = 0;
            if (g > 0)
            begin
                pixel_out.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            pixel_out.ready <= 1'b1;
            @(posedge clk);
            while (!pixel_out.valid)
                @(posedge clk);
            got.main_x = pixel_out.main_x;
            got.main_y = pixel_out.main_y;
            got.main_weight = pixel_out.main_weight;
            got.main_valid = pixel_out.main_valid;
            got.side_x = pixel_out.side_x;
            got.side_y = pixel_out.side_y;
            got.side_weight = pixel_out.side_weight;
            got.side_valid = pixel_out.side_valid;
            got.line_done = pixel_out.line_done;
            sb.check_pair(got);
        end
    end

    // register write with setup and access phases while the block is idle
    task automatic write_reg(logic idx, logic [12:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {19'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_WIDTH)
            sb.img_w = value;
        else
            sb.img_h = value;
        @(posedge clk);
    endtask

    // offer one command and wait for its transfer; valid stays high unless the next call begins with a gap
    task automatic send_command(logic op, logic signed [CB-1:0] x0, y0, x1, y1, bit gap);
        int g;
        g = gap ? gap_len() : 0;
        if (g > 0)
        begin
            line_in.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        line_in.valid <= 1'b1;
        line_in.op <= op;
        line_in.start_x <= x0;
        line_in.start_y <= y0;
        line_in.end_x <= x1;
        line_in.end_y <= y1;
        @(posedge clk);
        while (!line_in.ready)
            @(posedge clk);
        sb.note_command(op, x0, y0, x1, y1);
    endtask

    task automatic load_line(int x0, y0, x1, y1);
        send_command(OP_LOAD, CB'(x0), CB'(y0), CB'(x1), CB'(y1), 1);
    endtask

    task automatic step_pixels(int n);
        repeat (n) send_command(OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom),
                                CB'($urandom), 1);
    endtask

    // drain the result store, then let a stray load settle
    task automatic wait_idle();
        line_in.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // short random line mostly near the image, occasionally full-range endpoints
    task automatic random_line();
        int cx, cy, span;
        if ($urandom_range(0, 9) == 0)
            load_line($urandom, $urandom, $urandom, $urandom);
        else
        begin
            span = $urandom_range(0, 12);
            cx = $urandom_range(0, 40) - 10;
            cy = $urandom_range(0, 40) - 10;
            load_line(cx, cy, cx + $urandom_range(0, 2 * span) - span,
                      cy + $urandom_range(0, 2 * span) - span);
        end
    endtask

    initial
    begin : stimulus
        int cfg_w[4] = '{1, 4096, 20, 8191};
        int cfg_h[4] = '{4096, 1, 15, 0};
        int count;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: step with no line, zero length, shallow and steep lines, extremes, overflow
        step_pixels(1);
        load_line(5, 5, 5, 5);
        step_pixels(2);
        load_line(0, 0, 6, 2);   step_pixels(3);
        load_line(0, 0, 9, 3);   step_pixels(10);
        load_line(3, 0, 0, 7);   step_pixels(8);
        load_line(639, 479, 636, 478); step_pixels(4);
        load_line(-32768, 32767, 32767, -32768); step_pixels(3);
        load_line(32767, -1, 32766, 32767); step_pixels(2);
        load_line(-1, -32768, 2, -32767); step_pixels(2);
        wait_idle();

        // random phases across image settings; the first phase stalls the receiver
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(REG_WIDTH, 13'(cfg_w[ph-1]));
                write_reg(REG_HEIGHT, 13'(cfg_h[ph-1]));
            end
            if (ph == 0)
                hold_off = 1;
            count = 0;
            while (count < 160)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    step_pixels(1);
                    count++;
                end
                else
                begin
                    random_line();
                    // walk the line, stopping one step short of its end, at its end or past it
                    n = int'(sb.mend - sb.mpos) + int'($urandom_range(0, 3));
                    // long lines are only sampled at their start
                    if (n > 40)
                        n = int'($urandom_range(1, 8));
                    step_pixels(n);
                    count += 1 + n;
                end
            end
            wait_idle();
        end
        stim_done = 1;
    end

    initial
    begin : finisher
        wait (stim_done);
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

/* filelist.f */
src/als_pkg.sv
src/als_if.sv
src/als_front.sv
src/als_queue.sv
src/als_back.sv
src/antialiased_line_stepper.sv
tb/sv/tb.sv
